### rtl/rde_pkg.sv
// Shared constants, types and helpers for the radix digit emitter.
// No dependencies; imported by rde_div_step, rde_checker and the top level.
package rde_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_DIGITS_DEF = 31;
  localparam int DIGIT_W        = 4;
  localparam int STEP_BITS      = 8;
  localparam int OUT_TDATA_W    = 8;

  typedef logic [DIGIT_W-1:0] digit_t;

  localparam digit_t BASE_MIN = 4'd2;
  localparam digit_t BASE_MAX = 4'd10;

  function automatic digit_t clamp_base(input digit_t b);
    digit_t r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

endpackage

### rtl/radix_digit_emitter.sv
// Radix digit emitter: converts an unsigned integer to base 2..10 digits, MSB first.
// Each digit is formed in the shared divide slice, STEP_BITS value bits per pass; the digits
// then go through the digit store's read register and the output register, one digit per cycle
// while out_tready is high. New input is taken once the last digit is in the output register.
// Synchronous active-low reset clears control state; the digit store is not cleared.
// Depends on rde_pkg, rde_div_step, rde_ram.
module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = rde_pkg::MAX_DIGITS_DEF,
  localparam int IN_W = ((VALUE_BITS + rde_pkg::DIGIT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,   // value, base
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rde_pkg::OUT_TDATA_W-1:0] out_tdata,  // digit
  output logic                            out_tlast
);

  localparam int PASSES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W  = PASSES * STEP_BITS;
  localparam int PASS_W = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [PAD_W-1:0]    work_r, work_nxt;
  digit_t              rem_r, rem_nxt;
  digit_t              radix_r, radix_nxt;
  logic [PASS_W-1:0]   pass_r, pass_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                issued_all_r, issued_all_nxt;
  logic                rdv_r, rdv_nxt;
  logic                rd_last_r, rd_last_nxt;
  logic                out_valid_r, out_valid_nxt;
  digit_t              out_digit_r, out_digit_nxt;
  logic                out_last_r, out_last_nxt;

  digit_t              rem_step;
  logic [STEP_BITS-1:0] q_step;
  logic [PAD_W-1:0]    work_sh;
  logic                digit_done;
  logic                wr_en;
  logic                issue;
  logic                load;
  digit_t              rd_data;

  rde_div_step #(.STEP(STEP_BITS)) u_div_step (
    .radix   (radix_r),
    .rem_in  (rem_r),
    .bits_in (work_r[PAD_W-1 -: STEP_BITS]),
    .rem_out (rem_step),
    .q_out   (q_step)
  );

  rde_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_digit_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (rem_step),
    .re    (issue),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  assign work_sh    = (work_r << STEP_BITS) | PAD_W'(q_step);
  assign digit_done = (state_r == ST_DIV) && (pass_r == PASS_W'(PASSES - 1));
  assign wr_en      = digit_done;
  assign load       = rdv_r && (!out_valid_r || out_tready);
  assign issue      = (state_r == ST_EMIT) && !issued_all_r && (!rdv_r || load);

  always_comb begin
    state_nxt      = state_r;
    work_nxt       = work_r;
    rem_nxt        = rem_r;
    radix_nxt      = radix_r;
    pass_nxt       = pass_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    issued_all_nxt = issued_all_r;
    rdv_nxt        = rdv_r;
    rd_last_nxt    = rd_last_r;
    out_valid_nxt  = out_valid_r;
    out_digit_nxt  = out_digit_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          work_nxt  = PAD_W'(in_tdata[VALUE_BITS-1:0]);
          radix_nxt = clamp_base(in_tdata[VALUE_BITS +: DIGIT_W]);
          rem_nxt   = '0;
          pass_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        work_nxt = work_sh;
        if (digit_done) begin
          rem_nxt  = '0;
          pass_nxt = '0;
          cnt_nxt  = cnt_r + 1'b1;
          if ((work_sh == '0) || (cnt_r == CNT_W'(MAX_DIGITS - 1))) begin
            rd_idx_nxt     = cnt_r[ADDR_W-1:0];
            issued_all_nxt = 1'b0;
            rdv_nxt        = 1'b0;
            state_nxt      = ST_EMIT;
          end
        end else begin
          rem_nxt  = rem_step;
          pass_nxt = pass_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          rd_last_nxt = (rd_idx_r == '0);
          if (rd_idx_r == '0) issued_all_nxt = 1'b1;
          else                rd_idx_nxt     = rd_idx_r - 1'b1;
        end
        if (issue)     rdv_nxt = 1'b1;
        else if (load) rdv_nxt = 1'b0;
        if (load && rd_last_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
      out_digit_nxt = rd_data;
      out_last_nxt  = rd_last_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pass_r       <= '0;
      cnt_r        <= '0;
      issued_all_r <= 1'b0;
      rdv_r        <= 1'b0;
      rd_last_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pass_r       <= pass_nxt;
      cnt_r        <= cnt_nxt;
      issued_all_r <= issued_all_nxt;
      rdv_r        <= rdv_nxt;
      rd_last_r    <= rd_last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    rem_r       <= rem_nxt;
    radix_r     <= radix_nxt;
    rd_idx_r    <= rd_idx_nxt;
    out_digit_r <= out_digit_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_digit_r);
  assign out_tlast  = out_last_r;

endmodule

### rtl/rde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rde_div_step.sv
// Shared divide slice: STEP restoring-division steps by a small radix.
// Depends on rde_pkg.
module rde_div_step #(
  parameter int STEP = 8
) (
  input  rde_pkg::digit_t  radix,
  input  rde_pkg::digit_t  rem_in,
  input  logic [STEP-1:0]  bits_in,
  output rde_pkg::digit_t  rem_out,
  output logic [STEP-1:0]  q_out
);
  import rde_pkg::*;

  always_comb begin
    logic [DIGIT_W:0] part;
    digit_t           r;
    r     = rem_in;
    q_out = '0;
    for (int i = STEP - 1; i >= 0; i--) begin
      part = {r, bits_in[i]};
      if (part >= {1'b0, radix}) begin
        part     = part - {1'b0, radix};
        q_out[i] = 1'b1;
      end
      r = part[DIGIT_W-1:0];
    end
    rem_out = r;
  end

endmodule

### rtl/rde_checker.sv
// Port-level assertions for radix_digit_emitter, attached by bind.
// Depends on rde_pkg and radix_digit_emitter.
module rde_checker #(
  parameter int IN_W = 40
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [IN_W-1:0]                 in_tdata,   // value, base
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rde_pkg::OUT_TDATA_W-1:0] out_tdata,  // digit
  input logic                            out_tlast
);
  import rde_pkg::*;

  logic unused_in;
  assign unused_in = ^in_tdata;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while converting");

  a_no_early_digit: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid || out_tlast)
    else $error("digit of new word shown before conversion");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) && $past(rst_n) |-> out_tvalid && out_tlast)
    else $error("returned to idle without final digit");

endmodule

bind radix_digit_emitter rde_checker #(.IN_W(IN_W)) u_rde_checker (.*);
